// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define DCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define DCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/dct_pkg.sv =====
// types and constants of the double columnar transposition block
// no dependencies; used by dct_order, the top level and the checker
package dct_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned KEYLEN_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'd42;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_KEY      = 2'd0,
    REG_FIRST_KEY_LEN  = 2'd1,
    REG_SECOND_KEY     = 2'd2,
    REG_SECOND_KEY_LEN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAR_W-1:0] message_char;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cipher_char;
    logic              last_cipher;
    logic              truncated;
  } out_item_t;

endpackage

// ===== hw/rtl/dct_order.sv =====
// key column ordering unit: one shared character compare per cycle
// depends on dct_pkg
module dct_order #(
  parameter int unsigned MAX_KEY = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dct_pkg::KEY_W-1:0]    key_i,
  input  logic [$clog2(MAX_KEY+1)-1:0] klen_i,
  input  logic [$clog2(MAX_KEY)-1:0]   rank_i,
  output logic                         done_o,
  output logic [$clog2(MAX_KEY)-1:0]   col_o
);
  import dct_pkg::*;

  localparam int unsigned KI_W = $clog2(MAX_KEY);
  localparam int unsigned KL_W = $clog2(MAX_KEY + 1);

  logic              busy_q;
  logic              done_q;
  logic [KI_W-1:0]   c_q;
  logic [KI_W-1:0]   j_q;
  logic [KI_W-1:0]   cnt_q;
  logic [KI_W-1:0]   order_q [MAX_KEY];
  logic [CHAR_W-1:0] kch [MAX_KEY];
  logic [CHAR_W-1:0] kc;
  logic [CHAR_W-1:0] kj;
  logic              less;
  logic [KI_W-1:0]   cnt_fin;
  logic              j_last;
  logic              c_last;

  always_comb begin
    for (int i = 0; i < MAX_KEY; i++) begin
      kch[i] = key_i[i*CHAR_W +: CHAR_W];
    end
  end

  assign kc      = kch[c_q];
  assign kj      = kch[j_q];
  // equal characters rank by position
  assign less    = (kj < kc) || ((kj == kc) && (j_q < c_q));
  assign cnt_fin = cnt_q + KI_W'(less);
  assign j_last  = (KL_W'(j_q) + KL_W'(1)) == klen_i;
  assign c_last  = (KL_W'(c_q) + KL_W'(1)) == klen_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      c_q    <= '0;
      j_q    <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        c_q    <= '0;
        j_q    <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (j_last) begin
          j_q   <= '0;
          cnt_q <= '0;
          if (c_last) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            c_q <= c_q + KI_W'(1);
          end
        end else begin
          j_q   <= j_q + KI_W'(1);
          cnt_q <= cnt_fin;
        end
      end
    end
  end

  // inverse table: rank -> column
  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i && j_last) begin
      order_q[cnt_fin] <= c_q;
    end
  end

  assign done_o = done_q;
  assign col_o  = order_q[rank_i];

endmodule

// ===== hw/rtl/double_columnar_transposition.sv =====
// double columnar transposition cipher, encrypt direction, top level
// depends on dct_pkg and dct_order
//
// usage:
// - config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (first key,
//   first key length, second key, second key length); write only while idle
// - input channel: one plaintext byte per transfer; end_of_message closes the
//   message and starts the burst; bytes past MAX_MESSAGE are dropped and the
//   burst carries truncated on every byte
// - output channel: the whole ciphertext as one burst, last_cipher on its end
// - bytes load back to back while idle; in_stall_o stays high from the final
//   byte until the last ciphertext byte sits in the output register
// - per pass with n bytes, key length k and padded length p: p is found by
//   adding k until it is at least n, the column order by one shared compare per
//   cycle, then each byte takes a memory read (none for pad bytes), then a write,
//   and each column takes a step of its own
// - the output register holds a byte while out_stall_i is high; pass two
//   pauses until it is free
// - reset: keys clear, lengths go to 1, message count and overflow clear
module double_columnar_transposition #(
  parameter int unsigned MAX_MESSAGE = 48,
  parameter int unsigned MAX_KEY     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dct_pkg::KEY_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dct_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dct_pkg::out_item_t            out_data_o
);
  import dct_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_MESSAGE + 2 * MAX_KEY);
  localparam int unsigned MSG_AW = $clog2(MAX_MESSAGE);
  localparam int unsigned MID_D  = MAX_MESSAGE + MAX_KEY;
  localparam int unsigned MID_AW = $clog2(MID_D);
  localparam int unsigned KI_W   = $clog2(MAX_KEY);
  localparam int unsigned KL_W   = $clog2(MAX_KEY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_RANK = 6'b000100,
    S_COL  = 6'b001000,
    S_ADDR = 6'b010000,
    S_DATA = 6'b100000
  } state_e;

  // configuration registers
  logic [KEY_W-1:0]    key1_q, key2_q;
  logic [KEYLEN_W-1:0] klen1_q, klen2_q;

  // sequencer state
  state_e              state_q;
  logic                pass_q;   // 0: first key, 1: second key
  logic [CNT_W-1:0]    cnt_q;
  logic                ovf_q;
  logic [LEN_W-1:0]    n_q;      // source length of the current pass
  logic [LEN_W-1:0]    padded_q; // rounded up to whole rows
  logic [LEN_W-1:0]    idx_q;    // source index being read
  logic [KI_W-1:0]     r_q;      // column rank being read
  logic [MID_AW-1:0]   pos_q;    // write pointer into the middle text
  logic                pad_q;

  // memories
  logic [CHAR_W-1:0]   msg_mem [MAX_MESSAGE];
  logic [CHAR_W-1:0]   mid_mem [MID_D];
  logic [CHAR_W-1:0]   msg_rd_q, mid_rd_q;

  // output register
  logic                out_valid_q;
  out_item_t           out_q;

  // combinational
  logic                in_acc;
  logic                room;
  logic [CNT_W-1:0]    cnt_next;
  logic [KEYLEN_W-1:0] klen_raw;
  logic [KL_W-1:0]     klen_c;
  logic [KEY_W-1:0]    key_c;
  logic [LEN_W-1:0]    pad_sum;
  logic                pad_done;
  logic                order_done;
  logic [KI_W-1:0]     order_col;
  logic [LEN_W:0]      idx_sum;
  logic                col_end;
  logic                r_last;
  logic                advance;
  logic                last_c;
  logic [CHAR_W-1:0]   byte_c;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key1_q  <= '0;
      klen1_q <= KEYLEN_W'(1);
      key2_q  <= '0;
      klen2_q <= KEYLEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FIRST_KEY:      key1_q  <= cfg_wdata_i;
        REG_FIRST_KEY_LEN:  klen1_q <= cfg_wdata_i[KEYLEN_W-1:0];
        REG_SECOND_KEY:     key2_q  <= cfg_wdata_i;
        REG_SECOND_KEY_LEN: klen2_q <= cfg_wdata_i[KEYLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // key of the running pass; length clamped into 1..MAX_KEY
  assign key_c    = pass_q ? key2_q : key1_q;
  assign klen_raw = pass_q ? klen2_q : klen1_q;
  always_comb begin
    if (klen_raw == '0) begin
      klen_c = KL_W'(1);
    end else if (klen_raw > KEYLEN_W'(MAX_KEY)) begin
      klen_c = KL_W'(MAX_KEY);
    end else begin
      klen_c = klen_raw[KL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- load
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign room     = cnt_q < CNT_W'(MAX_MESSAGE);
  assign cnt_next = room ? cnt_q + CNT_W'(1) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && room) begin
      msg_mem[cnt_q[MSG_AW-1:0]] <= in_data_i.message_char;
    end
  end

  // ---------------------------------------------------------------- pad
  // padded length found by repeated add of the key length
  assign pad_sum  = padded_q + LEN_W'(klen_c);
  assign pad_done = (state_q == S_PAD) && (pad_sum >= n_q);

  // column order: rank -> column, one compare per cycle
  dct_order #(
    .MAX_KEY(MAX_KEY)
  ) u_order (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pad_done),
    .key_i  (key_c),
    .klen_i (klen_c),
    .rank_i (r_q),
    .done_o (order_done),
    .col_o  (order_col)
  );

  // ---------------------------------------------------------------- read out
  // source reads only where the index lies inside the text
  always_ff @(posedge clk_i) begin
    if ((state_q == S_ADDR) && !pass_q && (idx_q < n_q)) begin
      msg_rd_q <= msg_mem[idx_q[MSG_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_ADDR) && pass_q && (idx_q < n_q)) begin
      mid_rd_q <= mid_mem[idx_q[MID_AW-1:0]];
    end
  end

  assign byte_c  = pad_q ? PAD_CHAR : (pass_q ? mid_rd_q : msg_rd_q);
  // walk down a column in steps of the key length
  assign idx_sum = {1'b0, idx_q} + (LEN_W+1)'(klen_c);
  assign col_end = idx_sum >= {1'b0, padded_q};
  assign r_last  = (KL_W'(r_q) + KL_W'(1)) == klen_c;
  assign last_c  = pass_q && col_end && r_last;
  // pass two waits for a free output register
  assign advance = !pass_q || !out_valid_q || !out_stall_i;

  // first pass result goes to the middle text
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DATA) && !pass_q) begin
      mid_mem[pos_q] <= byte_c;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pass_q   <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      n_q      <= '0;
      padded_q <= '0;
      idx_q    <= '0;
      r_q      <= '0;
      pos_q    <= '0;
      pad_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q <= cnt_next;
            if (!room) begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.end_of_message) begin
              n_q      <= LEN_W'(cnt_next);
              padded_q <= '0;
              pass_q   <= 1'b0;
              pos_q    <= '0;
              state_q  <= S_PAD;
            end
          end
        end
        S_PAD: begin
          padded_q <= pad_sum;
          if (pad_done) begin
            state_q <= S_RANK;
          end
        end
        S_RANK: begin
          if (order_done) begin
            r_q     <= '0;
            state_q <= S_COL;
          end
        end
        S_COL: begin
          idx_q   <= LEN_W'(order_col);
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          pad_q   <= idx_q >= n_q;
          state_q <= S_DATA;
        end
        S_DATA: begin
          if (advance) begin
            if (!pass_q) begin
              pos_q <= pos_q + MID_AW'(1);
            end
            if (!col_end) begin
              idx_q   <= idx_sum[LEN_W-1:0];
              state_q <= S_ADDR;
            end else if (!r_last) begin
              r_q     <= r_q + KI_W'(1);
              state_q <= S_COL;
            end else if (!pass_q) begin
              // second pass takes the padded middle text
              pass_q   <= 1'b1;
              n_q      <= padded_q;
              padded_q <= '0;
              state_q  <= S_PAD;
            end else begin
              pass_q  <= 1'b0;
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DATA) && pass_q && advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DATA) && pass_q && advance) begin
      out_q.cipher_char <= byte_c;
      out_q.last_cipher <= last_c;
      out_q.truncated   <= ovf_q;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/dct_checker.sv =====
// port-level checks of the double columnar transposition top level
// depends on dct_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module dct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input dct_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dct_pkg::out_item_t out_data_o
);
  import dct_pkg::*;

  logic last_out_xfer;

  assign last_out_xfer = out_valid_o && !out_stall_i && out_data_o.last_cipher;

  // a stalled result byte stays put
  `DCT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // the closing byte of a message makes the block busy
  `DCT_ASSERT_NXT(a_busy_after_end, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.end_of_message, in_stall_o)

  // once the closing byte leaves an idle block nothing else is pending
  `DCT_ASSERT_NXT(a_burst_end, clk_i, rst_ni, last_out_xfer && !in_stall_o, !out_valid_o)

  // while loading, only the closing byte of a burst can still wait
  `DCT_ASSERT_IMP(a_idle_only_last, clk_i, rst_ni, !in_stall_o && out_valid_o, out_data_o.last_cipher)

endmodule

bind double_columnar_transposition dct_checker u_dct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
